>>> hdl/rtc_calendar_setter_core_assert.svh
// assertion macros for the calendar setter core
`ifndef RTC_CALENDAR_SETTER_CORE_ASSERT_SVH
`define RTC_CALENDAR_SETTER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define RTCCAL_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define RTCCAL_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RTCCAL_ASSERT(label, clk, rst, prop, msg)
`define RTCCAL_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

>>> hdl/rtccal_pkg.sv
// types, constants and helper functions for the calendar setter core
`default_nettype none
package rtccal_pkg;

  localparam logic [3:0] CMD_HOUR_UP    = 4'd0;
  localparam logic [3:0] CMD_HOUR_DOWN  = 4'd1;
  localparam logic [3:0] CMD_MIN_UP     = 4'd2;
  localparam logic [3:0] CMD_MIN_DOWN   = 4'd3;
  localparam logic [3:0] CMD_DAY_UP     = 4'd4;
  localparam logic [3:0] CMD_DAY_DOWN   = 4'd5;
  localparam logic [3:0] CMD_MONTH_UP   = 4'd6;
  localparam logic [3:0] CMD_MONTH_DOWN = 4'd7;
  localparam logic [3:0] CMD_YEAR_UP    = 4'd8;
  localparam logic [3:0] CMD_YEAR_DOWN  = 4'd9;
  localparam logic [3:0] CMD_LOAD       = 4'd10;

  localparam logic [6:0] HOUR_MAX   = 7'd23;
  localparam logic [6:0] MIN_MAX    = 7'd59;
  localparam logic [6:0] MONTH_MAX  = 7'd12;
  localparam logic [6:0] YEAR_MIN   = 7'd25;
  localparam logic [6:0] YEAR_MAX   = 7'd40;
  localparam logic [7:0] YEAR_BASE  = 8'd20;
  localparam logic [7:0] WEEKDAY    = 8'd6;

  localparam logic [1:0] REG_TIME       = 2'd0;
  localparam logic [1:0] REG_DATE       = 2'd3;
  localparam logic [2:0] TIME_BYTES     = 3'd3;
  localparam logic [2:0] DATE_BYTES     = 3'd4;

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 72;

  typedef struct packed {
    logic [5:0] hour;
    logic [6:0] minute;
    logic [5:0] day;
    logic [4:0] month;
    logic [6:0] year;
  } cal_state_t;

  typedef struct packed {
    logic        write_valid;
    logic [1:0]  start_register;
    logic [2:0]  byte_count;
    logic [7:0]  byte_zero;
    logic [7:0]  byte_one;
    logic [7:0]  byte_two;
    logic [7:0]  byte_three;
    logic [31:0] fat_time;
  } result_t;

  localparam cal_state_t CAL_RESET = '{hour: 6'd0, minute: 7'd0, day: 6'd1,
                                       month: 5'd1, year: 7'd25};

  function automatic logic [6:0] step_wrap(input logic [6:0] v, input logic up,
                                           input logic [6:0] lo, input logic [6:0] hi);
    logic [6:0] r;
    if (up) r = (v < hi) ? v + 7'd1 : lo;
    else    r = (v > lo) ? v - 7'd1 : hi;
    return r;
  endfunction

  function automatic logic [6:0] month_length(input logic [4:0] m);
    logic [6:0] r;
    if (m == 5'd2) r = 7'd29;
    else if (m == 5'd4 || m == 5'd6 || m == 5'd9 || m == 5'd11) r = 7'd30;
    else r = 7'd31;
    return r;
  endfunction

  // divide by ten through multiply by 205 and shift by 11, exact below 1029
  function automatic logic [7:0] to_bcd(input logic [6:0] v);
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  units;
    prod  = 15'(v) * 15'd205;
    tens  = prod[14:11];
    units = v - 7'({tens, 3'b000}) - 7'({tens, 1'b0});
    return {tens, units[3:0]};
  endfunction

  function automatic logic [7:0] from_bcd(input logic [7:0] raw, input logic [3:0] tens_mask);
    logic [3:0] tens;
    tens = raw[7:4] & tens_mask;
    return {4'b0000, raw[3:0]} + {1'b0, tens, 3'b000} + {3'b000, tens, 1'b0};
  endfunction

endpackage
`default_nettype wire

>>> hdl/rtccal_step.sv
// next calendar state and result for one command
`default_nettype none
module rtccal_step
  import rtccal_pkg::*;
(
  input  wire logic [3:0] command,
  input  wire logic [7:0] sec_reg,
  input  wire logic [7:0] min_reg,
  input  wire logic [7:0] hour_reg,
  input  wire logic [7:0] date_reg,
  input  wire logic [7:0] month_reg,
  input  wire logic [7:0] year_reg,
  input  wire logic       rtc_enable,
  input  wire cal_state_t cal,
  output cal_state_t      cal_next,
  output result_t         result
);

  logic       up;
  logic [7:0] dec_sec;
  logic [7:0] dec_min;
  logic [7:0] dec_hour;
  logic [7:0] dec_day;
  logic [7:0] dec_month;
  logic [7:0] dec_year;
  logic [7:0] sec;
  logic [7:0] year_off;

  assign up        = ~command[0];
  assign dec_sec   = from_bcd(sec_reg, 4'h7);
  assign dec_min   = from_bcd(min_reg, 4'h7);
  assign dec_hour  = from_bcd(hour_reg, 4'h3);
  assign dec_day   = from_bcd(date_reg, 4'h3);
  assign dec_month = from_bcd(month_reg, 4'h1);
  assign dec_year  = from_bcd(year_reg, 4'hf);

  always_comb begin
    cal_next = cal;
    sec      = 8'd0;
    unique case (command)
      CMD_HOUR_UP, CMD_HOUR_DOWN: begin
        cal_next.hour = 6'(step_wrap({1'b0, cal.hour}, up, 7'd0, HOUR_MAX));
      end
      CMD_MIN_UP, CMD_MIN_DOWN: begin
        cal_next.minute = step_wrap(cal.minute, up, 7'd0, MIN_MAX);
      end
      CMD_DAY_UP, CMD_DAY_DOWN: begin
        cal_next.day = 6'(step_wrap({1'b0, cal.day}, up, 7'd1, month_length(cal.month)));
      end
      CMD_MONTH_UP, CMD_MONTH_DOWN: begin
        cal_next.month = 5'(step_wrap({2'b00, cal.month}, up, 7'd1, MONTH_MAX));
      end
      CMD_YEAR_UP, CMD_YEAR_DOWN: begin
        cal_next.year = step_wrap(cal.year, up, YEAR_MIN, YEAR_MAX);
      end
      CMD_LOAD: begin
        if (rtc_enable) begin
          sec             = dec_sec;
          cal_next.minute = dec_min[6:0];
          cal_next.hour   = dec_hour[5:0];
          cal_next.day    = dec_day[5:0];
          cal_next.month  = dec_month[4:0];
          cal_next.year   = dec_year[6:0];
        end
      end
      default: begin
      end
    endcase
  end

  assign year_off = {1'b0, cal_next.year} + YEAR_BASE;

  always_comb begin
    result = '0;
    unique case (command)
      CMD_HOUR_UP, CMD_HOUR_DOWN, CMD_MIN_UP, CMD_MIN_DOWN: begin
        result.write_valid    = rtc_enable;
        result.start_register = REG_TIME;
        result.byte_count     = TIME_BYTES;
        result.byte_one       = to_bcd(cal_next.minute);
        result.byte_two       = to_bcd({1'b0, cal_next.hour});
      end
      CMD_DAY_UP, CMD_DAY_DOWN, CMD_MONTH_UP, CMD_MONTH_DOWN,
      CMD_YEAR_UP, CMD_YEAR_DOWN: begin
        result.write_valid    = rtc_enable;
        result.start_register = REG_DATE;
        result.byte_count     = DATE_BYTES;
        result.byte_zero      = WEEKDAY;
        result.byte_one       = to_bcd({1'b0, cal_next.day});
        result.byte_two       = to_bcd({2'b00, cal_next.month});
        result.byte_three     = to_bcd(cal_next.year);
      end
      CMD_LOAD: begin
        // fields overlap, so the terms are ored
        result.fat_time = {year_off[6:0], 25'd0}
                        | {6'd0, cal_next.month, 21'd0}
                        | {10'd0, cal_next.day, 16'd0}
                        | {15'd0, cal_next.hour, 11'd0}
                        | {20'd0, cal_next.minute, 5'd0}
                        | {25'd0, sec[7:1]};
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

>>> hdl/rtc_calendar_setter_core.sv
// Calendar setter core: one command in, one result out.
// Results are registered in the output register, or in the skid register while
// the output register waits on m_tready. Throughput: one command per cycle while
// the skid is empty; a two-entry output buffer (register plus skid) keeps
// s_tready high while one finished result waits on m_tready. Reset (rst,
// synchronous): time 00:00, day 1, month 1, year 25, rtc_enable 1, buffer empty.
`default_nettype none
`include "rtc_calendar_setter_core_assert.svh"
module rtc_calendar_setter_core
  import rtccal_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // sec_reg, min_reg, hour_reg, date_reg, month_reg, year_reg
  input  wire logic [IN_DATA_W-1:0]  s_tdata,
  // command
  input  wire logic [3:0]            s_tuser,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // write_valid, start_register, byte_count, byte_zero, byte_one, byte_two,
  // byte_three, fat_time, two zero bits
  output logic [OUT_DATA_W-1:0]      m_tdata,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic                  cfg_data
);

  logic                  rtc_enable;
  cal_state_t            cal;
  cal_state_t            cal_next;
  result_t               result;
  logic [OUT_DATA_W-1:0] result_data;
  logic                  push;
  logic                  pop;
  logic                  out_valid;
  logic [OUT_DATA_W-1:0] out_data;
  logic                  skid_valid;
  logic [OUT_DATA_W-1:0] skid_data;

  assign cfg_ready = 1'b1;
  assign s_tready  = ~skid_valid;
  assign push      = s_tvalid & s_tready;
  assign pop       = out_valid & m_tready;
  assign m_tvalid  = out_valid;
  assign m_tdata   = out_data;

  rtccal_step u_step (
    .command    (s_tuser),
    .sec_reg    (s_tdata[7:0]),
    .min_reg    (s_tdata[15:8]),
    .hour_reg   (s_tdata[23:16]),
    .date_reg   (s_tdata[31:24]),
    .month_reg  (s_tdata[39:32]),
    .year_reg   (s_tdata[47:40]),
    .rtc_enable (rtc_enable),
    .cal        (cal),
    .cal_next   (cal_next),
    .result     (result)
  );

  assign result_data = {2'b00, result.fat_time, result.byte_three, result.byte_two,
                        result.byte_one, result.byte_zero, result.byte_count,
                        result.start_register, result.write_valid};

  always_ff @(posedge clk) begin
    if (rst) begin
      rtc_enable <= 1'b1;
      cal        <= CAL_RESET;
    end else begin
      if (cfg_valid && cfg_ready) rtc_enable <= cfg_data;
      if (push) cal <= cal_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (pop) begin
        if (skid_valid) begin
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          out_valid <= push;
        end
      end else if (!out_valid) begin
        out_valid <= push;
      end else if (push) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && skid_valid) begin
      out_data <= skid_data;
    end else if (push && (pop || !out_valid)) begin
      out_data <= result_data;
    end
    if (push && out_valid && !pop) skid_data <= result_data;
  end

  // a waiting skid entry always has a result ahead of it
  `RTCCAL_ASSERT(a_skid_behind_out, clk, rst, skid_valid |-> out_valid,
                 "skid entry without an output entry")
  // an up step never ends above the maximum; a down step from a loaded value may
  `RTCCAL_ASSERT(a_hour_step_range, clk, rst,
                 (push && s_tuser == CMD_HOUR_UP) |=> (cal.hour <= 6'd23),
                 "hour above its maximum after an up step")
  `RTCCAL_ASSERT(a_year_step_range, clk, rst,
                 (push && s_tuser == CMD_YEAR_UP) |=> (cal.year <= YEAR_MAX),
                 "year above its maximum after an up step")
  `RTCCAL_ASSERT(a_month_step_range, clk, rst,
                 (push && s_tuser == CMD_MONTH_UP) |=> (cal.month <= 5'd12),
                 "month above its maximum after an up step")
  `RTCCAL_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> (!out_valid && !skid_valid),
                        "output buffer not empty after reset")

endmodule
`default_nettype wire

>>> verif/tb.sv
// testbench for the rtc calendar setter core: step, load and clock-enable checks
module tb;
  import rtccal_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 60;

  localparam logic [3:0] CMD_UNUSED_LO = 4'd11;
  localparam logic [3:0] CMD_UNUSED_HI = 4'd15;

  localparam int HOUR_TOP        = 23;
  localparam int MINUTE_TOP      = 59;
  localparam int MONTH_TOP       = 12;
  localparam int YEAR_FIRST      = 25;
  localparam int YEAR_LAST       = 40;
  localparam int FAT_YEAR_OFFSET = 20;
  localparam logic [7:0] FIXED_WEEKDAY   = 8'd6;
  localparam logic [1:0] TIME_START_REG  = 2'd0;
  localparam logic [1:0] DATE_START_REG  = 2'd3;
  localparam logic [2:0] TIME_LEN        = 3'd3;
  localparam logic [2:0] DATE_LEN        = 3'd4;

  // m_tdata layout, lowest bit last
  typedef struct packed {
    logic [1:0]  pad;
    logic [31:0] fat_time;
    logic [7:0]  byte_three;
    logic [7:0]  byte_two;
    logic [7:0]  byte_one;
    logic [7:0]  byte_zero;
    logic [2:0]  byte_count;
    logic [1:0]  start_register;
    logic        write_valid;
  } clock_write_t;

  typedef struct {
    logic [5:0] hr;
    logic [6:0] mn;
    logic [5:0] dy;
    logic [4:0] mo;
    logic [6:0] yr;
  } calendar_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic [3:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_data = 1'b0;

  rtc_calendar_setter_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // sec_reg, min_reg, hour_reg, date_reg, month_reg, year_reg
    .s_tuser  (s_tuser),   // command
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),   // write_valid, start_register, byte_count, byte_zero..byte_three,
                           // fat_time, two zero bits
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  calendar_t    cal;
  logic         rtc_on;
  clock_write_t expected_writes[$];
  int           sent_count = 0;
  int           checked_count = 0;
  int           mismatches = 0;
  int           cycle_count = 0;
  bit           tx_gaps = 1'b1;
  bit           rx_gaps = 1'b1;
  int           hold_gen = 0;
  int           hold_seen = 0;
  int           hold_left = 0;
  int           stall_left = 0;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_writes.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // result side ready: random stall bursts plus long hold-offs on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_gen) begin
      hold_seen <= hold_gen;
      hold_left <= HOLD_CYCLES - 1;
      m_tready  <= 1'b0;
    end else if (stall_left > 0) begin
      m_tready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (rx_gaps && $urandom_range(0, 5) == 0) begin
      m_tready   <= 1'b0;
      stall_left <= $urandom_range(0, 4);
    end else begin
      m_tready <= 1'b1;
    end
  end

  function automatic int stepped(input int v, input bit up, input int lo, input int hi);
    if (up) return (v < hi) ? v + 1 : lo;
    return (v > lo) ? v - 1 : hi;
  endfunction

  function automatic int days_in_month(input int m);
    if (m == 2) return 29;
    if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
    return 31;
  endfunction

  function automatic logic [7:0] to_bcd_byte(input int v);
    return 8'((((v / 10) << 4) | (v % 10)) & 8'hff);
  endfunction

  function automatic int decode_bcd(input logic [7:0] raw, input int tens_mask);
    return int'(raw[3:0]) + 10 * (int'(raw[7:4]) & tens_mask);
  endfunction

  function automatic logic [47:0] clock_regs(input int sec, input int mn, input int hr,
                                             input int dy, input int mo, input int yr);
    return {to_bcd_byte(yr), to_bcd_byte(mo), to_bcd_byte(dy),
            to_bcd_byte(hr), to_bcd_byte(mn), to_bcd_byte(sec)};
  endfunction

  // advances the calendar copy and returns the register write the request causes
  function automatic clock_write_t predict_clock_write(input logic [3:0] cmd,
                                                       input logic [47:0] regs);
    clock_write_t w;
    bit up;
    int sec;
    w   = '0;
    up  = ~cmd[0];
    sec = 0;
    if (cmd <= CMD_MIN_DOWN) begin
      if (cmd <= CMD_HOUR_DOWN) cal.hr = 6'(stepped(cal.hr, up, 0, HOUR_TOP));
      else cal.mn = 7'(stepped(cal.mn, up, 0, MINUTE_TOP));
      w.write_valid    = rtc_on;
      w.start_register = TIME_START_REG;
      w.byte_count     = TIME_LEN;
      w.byte_one       = to_bcd_byte(cal.mn);
      w.byte_two       = to_bcd_byte(cal.hr);
    end else if (cmd <= CMD_YEAR_DOWN) begin
      if (cmd <= CMD_DAY_DOWN) cal.dy = 6'(stepped(cal.dy, up, 1, days_in_month(cal.mo)));
      else if (cmd <= CMD_MONTH_DOWN) cal.mo = 5'(stepped(cal.mo, up, 1, MONTH_TOP));
      else cal.yr = 7'(stepped(cal.yr, up, YEAR_FIRST, YEAR_LAST));
      w.write_valid    = rtc_on;
      w.start_register = DATE_START_REG;
      w.byte_count     = DATE_LEN;
      w.byte_zero      = FIXED_WEEKDAY;
      w.byte_one       = to_bcd_byte(cal.dy);
      w.byte_two       = to_bcd_byte(cal.mo);
      w.byte_three     = to_bcd_byte(cal.yr);
    end else if (cmd == CMD_LOAD) begin
      if (rtc_on) begin
        sec    = decode_bcd(regs[7:0], 7);
        cal.mn = 7'(decode_bcd(regs[15:8], 7));
        cal.hr = 6'(decode_bcd(regs[23:16], 3));
        cal.dy = 6'(decode_bcd(regs[31:24], 3));
        cal.mo = 5'(decode_bcd(regs[39:32], 1));
        cal.yr = 7'(decode_bcd(regs[47:40], 15));
      end
      w.fat_time = ((32'(cal.yr) + 32'(FAT_YEAR_OFFSET)) << 25) | (32'(cal.mo) << 21)
                 | (32'(cal.dy) << 16) | (32'(cal.hr) << 11) | (32'(cal.mn) << 5)
                 | (32'(sec) >> 1);
    end
    return w;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on result %0d, %s: expected 0x%0h, got 0x%0h",
                 checked_count, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    clock_write_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = clock_write_t'(m_tdata);
      if (expected_writes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result 0x%0h", m_tdata);
      end else begin
        want = expected_writes.pop_front();
        check_field("write_valid", 32'(want.write_valid), 32'(got.write_valid));
        check_field("start_register", 32'(want.start_register), 32'(got.start_register));
        check_field("byte_count", 32'(want.byte_count), 32'(got.byte_count));
        check_field("byte_zero", 32'(want.byte_zero), 32'(got.byte_zero));
        check_field("byte_one", 32'(want.byte_one), 32'(got.byte_one));
        check_field("byte_two", 32'(want.byte_two), 32'(got.byte_two));
        check_field("byte_three", 32'(want.byte_three), 32'(got.byte_three));
        check_field("fat_time", want.fat_time, got.fat_time);
        check_field("pad bits", 32'(want.pad), 32'(got.pad));
      end
      checked_count++;
    end
  end

  // called at a clock edge; returns at the edge where the request is taken
  task automatic send_request(input logic [3:0] cmd, input logic [47:0] regs);
    if (tx_gaps && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= regs;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected_writes.push_back(predict_clock_write(cmd, regs));
    sent_count++;
  endtask

  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    while (expected_writes.size() != 0) @(posedge clk);
  endtask

  task automatic set_rtc_enable(input logic v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    rtc_on = v;
  endtask

  function automatic logic [47:0] random_regs();
    return 48'({$urandom, $urandom});
  endfunction

  task automatic test_time_steps();
    send_request(CMD_HOUR_DOWN, random_regs());   // 0 wraps to 23
    send_request(CMD_HOUR_UP, random_regs());     // 23 wraps to 0
    send_request(CMD_MIN_DOWN, random_regs());    // 0 wraps to 59
    send_request(CMD_MIN_UP, random_regs());
    wait_for_results();
  endtask

  task automatic test_date_steps();
    send_request(CMD_DAY_DOWN, '0);     // january: 1 wraps to 31
    send_request(CMD_DAY_UP, '0);
    send_request(CMD_MONTH_DOWN, '0);   // 1 wraps to 12
    send_request(CMD_MONTH_UP, '0);
    send_request(CMD_MONTH_UP, '0);
    send_request(CMD_DAY_DOWN, '0);     // february tops out at 29
    send_request(CMD_YEAR_DOWN, '0);    // 25 wraps to 40
    send_request(CMD_YEAR_UP, '0);
    wait_for_results();
  endtask

  task automatic test_load_decode();
    // all ones: masked tens digits, fields beyond their ranges
    send_request(CMD_LOAD, {48{1'b1}});
    send_request(CMD_HOUR_UP, '0);      // above the maximum goes to the minimum
    send_request(CMD_DAY_DOWN, '0);
    send_request(CMD_LOAD, '0);         // zero day and month below the minimum
    send_request(CMD_DAY_DOWN, '0);
    send_request(CMD_LOAD, {8'h9f, 40'h0});
    send_request(CMD_YEAR_DOWN, '0);    // year above 99 in bcd
    send_request(CMD_LOAD, clock_regs(59, 59, 23, 31, 12, 40));
    wait_for_results();
  endtask

  task automatic test_undefined_commands();
    logic [3:0] cmd;
    for (cmd = CMD_UNUSED_LO; cmd != CMD_UNUSED_HI; cmd++) send_request(cmd, random_regs());
    send_request(CMD_UNUSED_HI, random_regs());
    wait_for_results();
  endtask

  task automatic test_clock_absent();
    set_rtc_enable(1'b0);
    send_request(CMD_MIN_UP, '0);
    send_request(CMD_MONTH_DOWN, '0);
    send_request(CMD_LOAD, random_regs());   // state kept, seconds zero
    wait_for_results();
    set_rtc_enable(1'b1);
  endtask

  task automatic test_random_traffic(input int count);
    int i;
    int pick;
    logic [3:0] cmd;
    logic [47:0] regs;
    for (i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      regs = random_regs();
      if (pick < 70) begin
        cmd = 4'($urandom_range(CMD_HOUR_UP, CMD_YEAR_DOWN));
      end else if (pick < 85) begin
        cmd  = CMD_LOAD;
        regs = clock_regs($urandom_range(0, 59), $urandom_range(0, MINUTE_TOP),
                          $urandom_range(0, HOUR_TOP), $urandom_range(1, 31),
                          $urandom_range(1, MONTH_TOP),
                          $urandom_range(YEAR_FIRST, YEAR_LAST));
      end else if (pick < 95) begin
        cmd = CMD_LOAD;
      end else begin
        cmd = 4'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
      end
      send_request(cmd, regs);
    end
  endtask

  task automatic test_backpressure();
    hold_gen <= hold_gen + 1;
    test_random_traffic(30);
    wait_for_results();
  endtask

  task automatic test_sender_pause();
    test_random_traffic(20);
    wait_for_results();
    test_random_traffic(20);
    wait_for_results();
  endtask

  initial begin
    cal    = '{hr: 6'd0, mn: 7'd0, dy: 6'd1, mo: 5'd1, yr: 7'(YEAR_FIRST)};
    rtc_on = 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_time_steps();
    test_date_steps();
    test_load_decode();
    test_undefined_commands();
    test_clock_absent();

    test_random_traffic(300);
    wait_for_results();
    set_rtc_enable(1'b0);
    test_random_traffic(150);
    wait_for_results();
    set_rtc_enable(1'b1);
    test_random_traffic(200);
    wait_for_results();
    test_backpressure();
    test_sender_pause();

    // closing stretch at full rate on both sides
    tx_gaps = 1'b0;
    rx_gaps <= 1'b0;
    test_random_traffic(150);
    wait_for_results();
    repeat (5) @(posedge clk);

    if (expected_writes.size() != 0) mismatches++;
    $display("%0d requests sent: all step commands with wraps, loads of valid and raw bcd,",
             sent_count);
    $display("undefined commands, clock present and absent; %0d results checked",
             checked_count);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+hdl
hdl/rtccal_pkg.sv
hdl/rtccal_step.sv
hdl/rtc_calendar_setter_core.sv
verif/tb.sv
